// ----- hw/rtl/tsp_pkg.sv -----
`timescale 1ns / 1ps
package tsp_pkg;

    // Largest page the block will fill
    localparam int PAGE_BITS_MAX = 65536;

    // Code segments per sample: exponent, time prefix, time field, value prefix, value bits
    localparam int NUM_SEG = 5;

    typedef enum logic [2:0] {
        CFG_PAGE_BITS  = 3'd0,
        CFG_START_POS  = 3'd1,
        CFG_INIT_TIME  = 3'd2,
        CFG_INIT_DELTA = 3'd3,
        CFG_INIT_VALUE = 3'd4,
        CFG_INIT_EXP   = 3'd5,
        CFG_INIT_LEAD  = 3'd6,
        CFG_INIT_WLEN  = 3'd7
    } t_cfg_reg;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DDT,
        F_SCAN,
        F_DIV,
        F_TIER,
        F_CLASS,
        F_PUSH
    } t_front_state;

    // One code segment, right aligned, first bit most significant
    typedef struct packed {
        logic [6:0]  len;
        logic [63:0] bits;
    } t_seg;

    // Classified sample handed from front to back
    typedef struct packed {
        logic                    full;
        t_seg [NUM_SEG-1:0]      seg;
    } t_job;

    // Ones in the low n bits, n up to 64
    function automatic logic [63:0] len_mask(input logic [6:0] n);
        logic [63:0] m;
        if (n >= 7'd64) begin
            m = '1;
        end else begin
            m = (64'd1 << n) - 64'd1;
        end
        return m;
    endfunction

    // Width of the wide time field for each exponent
    function automatic logic [6:0] wide_bits(input logic [2:0] e);
        logic [6:0] w;
        unique case (e)
            3'd0: w = 7'd64;
            3'd1: w = 7'd61;
            3'd2: w = 7'd58;
            3'd3: w = 7'd55;
            3'd4: w = 7'd51;
            3'd5: w = 7'd48;
            3'd6: w = 7'd45;
            default: w = 7'd41;
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/tsp_in_if.sv -----
`timescale 1ns / 1ps
interface tsp_in_if;
    logic        valid;
    logic        ready;
    logic [62:0] time_stamp;
    logic [63:0] value_bits;

    modport source (output valid, time_stamp, value_bits, input ready);
    modport sink   (input valid, time_stamp, value_bits, output ready);
endinterface

// ----- hw/rtl/tsp_out_if.sv -----
`timescale 1ns / 1ps
interface tsp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] chunk_bits;
    logic [6:0]  chunk_len;
    logic        last;
    logic        status;

    modport source (output valid, chunk_bits, chunk_len, last, status, input ready);
    modport sink   (input valid, chunk_bits, chunk_len, last, status, output ready);
endinterface

// ----- hw/rtl/tsp_front.sv -----
`timescale 1ns / 1ps
module tsp_front
    import tsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    tsp_in_if.sink      i_smp,
    output t_job        o_job,
    output logic        o_job_valid,
    input  logic        i_job_ready
);

    // Leading zeros of a byte
    function automatic logic [3:0] clz8(input logic [7:0] b);
        logic [3:0] c;
        logic       f;
        c = 4'd0;
        f = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!f) begin
                if (b[i]) f = 1'b1;
                else      c = c + 4'd1;
            end
        end
        return c;
    endfunction

    // Trailing zeros of a byte
    function automatic logic [3:0] ctz8(input logic [7:0] b);
        logic [3:0] c;
        logic       f;
        c = 4'd0;
        f = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!f) begin
                if (b[i]) f = 1'b1;
                else      c = c + 4'd1;
            end
        end
        return c;
    endfunction

    // Byte-wise search for the leading zero count
    function automatic logic [6:0] clz64(input logic [63:0] x);
        logic [6:0] c;
        logic       f;
        c = 7'd64;
        f = 1'b0;
        for (int b = 7; b >= 0; b--) begin
            if (!f && x[b*8 +: 8] != 8'd0) begin
                c = 7'((7 - b) * 8) + {3'd0, clz8(x[b*8 +: 8])};
                f = 1'b1;
            end
        end
        return c;
    endfunction

    function automatic logic [6:0] ctz64(input logic [63:0] x);
        logic [6:0] c;
        logic       f;
        c = 7'd64;
        f = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (!f && x[b*8 +: 8] != 8'd0) begin
                c = 7'(b * 8) + {3'd0, ctz8(x[b*8 +: 8])};
                f = 1'b1;
            end
        end
        return c;
    endfunction

    // Eight restoring steps of long division by ten
    function automatic logic [11:0] div10_byte(input logic [3:0] rem, input logic [7:0] b);
        logic [4:0] r;
        logic [7:0] q;
        r = {1'b0, rem};
        q = 8'd0;
        for (int i = 7; i >= 0; i--) begin
            r = {r[3:0], b[i]};
            if (r >= 5'd10) begin
                r    = r - 5'd10;
                q[i] = 1'b1;
            end
        end
        return {r[3:0], q};
    endfunction

    t_front_state r_state, n_state;

    // Sample state
    logic [62:0] r_prev_time,  n_prev_time;
    logic [63:0] r_prev_delta, n_prev_delta;
    logic [63:0] r_prev_value, n_prev_value;
    logic [2:0]  r_exp,        n_exp;
    logic [4:0]  r_lead,       n_lead;
    logic [6:0]  r_wlen,       n_wlen;
    logic [16:0] r_bit_pos,    n_bit_pos;
    logic [16:0] r_page_bits,  n_page_bits;

    // Work registers
    logic [62:0] r_t,     n_t;
    logic [63:0] r_v,     n_v;
    logic [63:0] r_dt,    n_dt;
    logic [63:0] r_quot,  n_quot;
    logic [63:0] r_x,     n_x;
    logic        r_zero,  n_zero;
    logic        r_neg,   n_neg;
    logic [6:0]  r_lz,    n_lz;
    logic [6:0]  r_tz,    n_tz;
    logic [2:0]  r_k,     n_k;
    logic [63:0] r_dwork, n_dwork;
    logic [63:0] r_nq,    n_nq;
    logic [3:0]  r_rem,   n_rem;
    logic [2:0]  r_step,  n_step;
    logic [63:0] r_m,     n_m;
    t_seg        r_vpre,  n_vpre;
    t_seg        r_vdat,  n_vdat;
    logic [4:0]  r_nl,    n_nl;
    logic [6:0]  r_nw,    n_nw;
    t_job        r_job,   n_job;

    // Combinational helpers
    logic [63:0] mag;
    logic [11:0] dres;
    logic [63:0] nq;
    logic [4:0]  pre;
    logic [6:0]  vlen;
    logic        reuse;
    logic [6:0]  sm_n;
    logic [63:0] sm;
    logic [2:0]  e_fin;
    logic [7:0]  total;
    logic [16:0] cap;
    logic [16:0] avail;
    logic        full;

    assign i_smp.ready = (r_state == F_IDLE);
    assign o_job       = r_job;
    // Beat is offered only once the page check has settled
    assign o_job_valid = (r_state == F_PUSH) && (r_step != 3'd0);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_prev_time  <= '0;
            r_prev_delta <= '0;
            r_prev_value <= '0;
            r_exp        <= 3'd7;
            r_lead       <= '0;
            r_wlen       <= '0;
            r_bit_pos    <= '0;
            r_page_bits  <= 17'(PAGE_BITS_MAX);
        end else begin
            r_state      <= n_state;
            r_prev_time  <= n_prev_time;
            r_prev_delta <= n_prev_delta;
            r_prev_value <= n_prev_value;
            r_exp        <= n_exp;
            r_lead       <= n_lead;
            r_wlen       <= n_wlen;
            r_bit_pos    <= n_bit_pos;
            r_page_bits  <= n_page_bits;
        end
    end

    // Work registers carry no reset
    always_ff @(posedge i_clk) begin
        r_t     <= n_t;
        r_v     <= n_v;
        r_dt    <= n_dt;
        r_quot  <= n_quot;
        r_x     <= n_x;
        r_zero  <= n_zero;
        r_neg   <= n_neg;
        r_lz    <= n_lz;
        r_tz    <= n_tz;
        r_k     <= n_k;
        r_dwork <= n_dwork;
        r_nq    <= n_nq;
        r_rem   <= n_rem;
        r_step  <= n_step;
        r_m     <= n_m;
        r_vpre  <= n_vpre;
        r_vdat  <= n_vdat;
        r_nl    <= n_nl;
        r_nw    <= n_nw;
        r_job   <= n_job;
    end

    // Sequencer: difference, scan, divide by ten, tier, classify, hand over
    always_comb begin
        n_state      = r_state;
        n_prev_time  = r_prev_time;
        n_prev_delta = r_prev_delta;
        n_prev_value = r_prev_value;
        n_exp        = r_exp;
        n_lead       = r_lead;
        n_wlen       = r_wlen;
        n_bit_pos    = r_bit_pos;
        n_page_bits  = r_page_bits;
        n_t          = r_t;
        n_v          = r_v;
        n_dt         = r_dt;
        n_quot       = r_quot;
        n_x          = r_x;
        n_zero       = r_zero;
        n_neg        = r_neg;
        n_lz         = r_lz;
        n_tz         = r_tz;
        n_k          = r_k;
        n_dwork      = r_dwork;
        n_nq         = r_nq;
        n_rem        = r_rem;
        n_step       = r_step;
        n_m          = r_m;
        n_vpre       = r_vpre;
        n_vdat       = r_vdat;
        n_nl         = r_nl;
        n_nw         = r_nw;
        n_job        = r_job;

        mag   = r_quot[63] ? (64'd0 - r_quot) : r_quot;
        dres  = div10_byte(r_rem, r_dwork[63:56]);
        nq    = {r_nq[55:0], dres[7:0]};
        pre   = (r_lz > 7'd31) ? 5'd31 : r_lz[4:0];
        vlen  = 7'(8'd64 - {3'd0, pre} - {1'b0, r_tz});
        reuse = (r_x != 64'd0) && (r_wlen != 7'd0)
              && ({3'd0, r_lead} + {1'b0, r_wlen} <= 8'd64)
              && (pre >= r_lead)
              && ({3'd0, pre} + {1'b0, vlen} <= {3'd0, r_lead} + {1'b0, r_wlen});
        e_fin = r_zero ? r_exp : r_k;
        if (r_m <= 64'd63) begin
            sm_n = 7'd7;
        end else if (r_m <= 64'd2047) begin
            sm_n = 7'd12;
        end else begin
            sm_n = wide_bits(r_k);
        end
        sm    = (r_m & len_mask(sm_n - 7'd1)) | ({63'd0, r_neg} << (sm_n - 7'd1));
        total = 8'd0;
        for (int s = 0; s < NUM_SEG; s++) begin
            total = total + {1'b0, r_job.seg[s].len};
        end
        cap   = ({4'd0, r_page_bits} < 21'(PAGE_BITS_MAX)) ? r_page_bits
              : 17'(PAGE_BITS_MAX);
        avail = (r_bit_pos < cap) ? (cap - r_bit_pos) : 17'd0;
        full  = {9'd0, total} > avail;

        unique case (r_state)
            F_IDLE: begin
                if (i_smp.valid) begin
                    n_t     = i_smp.time_stamp;
                    n_v     = i_smp.value_bits;
                    n_dt    = {1'b0, i_smp.time_stamp} - {1'b0, r_prev_time};
                    n_state = F_DDT;
                end
            end
            F_DDT: begin
                n_quot  = r_dt - r_prev_delta;
                n_x     = r_v ^ r_prev_value;
                n_state = F_SCAN;
            end
            F_SCAN: begin
                n_zero  = (r_quot == 64'd0);
                n_neg   = r_quot[63];
                n_quot  = mag;
                n_lz    = clz64(r_x);
                n_tz    = ctz64(r_x);
                n_k     = 3'd0;
                n_dwork = mag;
                n_rem   = 4'd0;
                n_step  = 3'd0;
                n_state = (mag != 64'd0 && r_exp != 3'd0) ? F_DIV : F_TIER;
            end
            F_DIV: begin
                n_nq    = nq;
                n_dwork = {r_dwork[55:0], 8'd0};
                n_rem   = dres[11:8];
                n_step  = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    if (dres[11:8] == 4'd0) begin
                        n_quot  = nq;
                        n_k     = r_k + 3'd1;
                        n_dwork = nq;
                        n_rem   = 4'd0;
                        if (r_k + 3'd1 == r_exp) n_state = F_TIER;
                    end else begin
                        n_state = F_TIER;
                    end
                end
            end
            F_TIER: begin
                n_m = r_neg ? r_quot : (r_quot - 64'd1);
                n_nl = r_lead;
                n_nw = r_wlen;
                if (r_x == 64'd0) begin
                    n_vpre = '{len: 7'd1, bits: 64'd0};
                    n_vdat = '{len: 7'd0, bits: 64'd0};
                end else if (reuse) begin
                    n_vpre = '{len: 7'd2, bits: 64'd2};
                    n_vdat = '{len: r_wlen,
                               bits: (r_x >> (7'd64 - {2'd0, r_lead} - r_wlen))
                                     & len_mask(r_wlen)};
                end else begin
                    n_vpre = '{len: 7'd13, bits: {51'd0, 2'b11, pre, vlen[5:0]}};
                    n_vdat = '{len: vlen, bits: (r_x >> r_tz) & len_mask(vlen)};
                    n_nl   = pre;
                    n_nw   = vlen;
                end
                n_state = F_CLASS;
            end
            F_CLASS: begin
                // segments first, page check on the next cycle in F_PUSH entry
                n_job.full   = 1'b0;
                n_job.seg[3] = r_vpre;
                n_job.seg[4] = r_vdat;
                if (r_zero) begin
                    n_job.seg[0] = '{len: 7'd0, bits: 64'd0};
                    n_job.seg[1] = '{len: 7'd1, bits: 64'd0};
                    n_job.seg[2] = '{len: 7'd0, bits: 64'd0};
                end else begin
                    n_job.seg[0] = '{len: (r_k != r_exp) ? 7'd7 : 7'd0,
                                     bits: {57'd0, 4'b1111, r_k}};
                    if (r_m <= 64'd63) begin
                        n_job.seg[1] = '{len: 7'd2, bits: 64'd2};
                    end else if (r_m <= 64'd2047) begin
                        n_job.seg[1] = '{len: 7'd3, bits: 64'd6};
                    end else begin
                        n_job.seg[1] = '{len: 7'd4, bits: 64'd14};
                    end
                    n_job.seg[2] = '{len: sm_n, bits: sm};
                end
                n_state = F_PUSH;
                n_step  = 3'd0;
            end
            F_PUSH: begin
                // First cycle settles the page check, commits state if it fits
                if (r_step == 3'd0) begin
                    n_step = 3'd1;
                    if (full) begin
                        n_job.full = 1'b1;
                    end else begin
                        n_prev_time  = r_t;
                        n_prev_delta = r_dt;
                        n_prev_value = r_v;
                        n_exp        = e_fin;
                        n_lead       = r_nl;
                        n_wlen       = r_nw;
                        n_bit_pos    = r_bit_pos + {9'd0, total};
                    end
                end else if (i_job_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase

        // Register writes load the matching state directly
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_PAGE_BITS:  n_page_bits  = i_cfg_data[16:0];
                CFG_START_POS:  n_bit_pos    = {1'b0, i_cfg_data[15:0]};
                CFG_INIT_TIME:  n_prev_time  = i_cfg_data[62:0];
                CFG_INIT_DELTA: n_prev_delta = {1'b0, i_cfg_data[62:0]};
                CFG_INIT_VALUE: n_prev_value = i_cfg_data;
                CFG_INIT_EXP:   n_exp        = i_cfg_data[2:0];
                CFG_INIT_LEAD:  n_lead       = i_cfg_data[4:0];
                CFG_INIT_WLEN:  n_wlen       = i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- hw/rtl/tsp_queue.sv -----
`timescale 1ns / 1ps
module tsp_queue
    import tsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_job,
    input  logic i_push_valid,
    output logic o_push_ready,
    output t_job o_job,
    output logic o_pop_valid,
    input  logic i_pop_ready
);

    t_job       r_ent [2];
    logic       r_wr,  n_wr;
    logic       r_rd,  n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_job        = r_ent[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Two-entry ring of classified beats
    always_comb begin
        n_wr  = push ? ~r_wr : r_wr;
        n_rd  = pop  ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_ent[r_wr] <= i_job;
    end

endmodule

// ----- hw/rtl/tsp_back.sv -----
`timescale 1ns / 1ps
module tsp_back
    import tsp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_job   i_job,
    input  logic   i_job_valid,
    output logic   o_job_ready,
    tsp_out_if.source o_chk
);

    logic         r_busy,   n_busy;
    t_job         r_job,    n_job;
    logic [2:0]   r_seg,    n_seg;
    logic [127:0] r_acc,    n_acc;
    logic [7:0]   r_accn,   n_accn;
    logic         r_ovalid, n_ovalid;
    logic [63:0]  r_obits,  n_obits;
    logic [6:0]   r_olen,   n_olen;
    logic         r_olast,  n_olast;
    logic         r_ostat,  n_ostat;
    logic         out_free;
    logic         segs_left;
    t_seg         cur;
    logic [127:0] top;

    assign o_job_ready      = !r_busy;
    assign o_chk.valid      = r_ovalid;
    assign o_chk.chunk_bits = r_obits;
    assign o_chk.chunk_len  = r_olen;
    assign o_chk.last       = r_olast;
    assign o_chk.status     = r_ostat;

    // Append segments into the bit accumulator, peel off 64-bit chunks
    always_comb begin
        n_busy   = r_busy;
        n_job    = r_job;
        n_seg    = r_seg;
        n_acc    = r_acc;
        n_accn   = r_accn;
        n_ovalid = r_ovalid;
        n_obits  = r_obits;
        n_olen   = r_olen;
        n_olast  = r_olast;
        n_ostat  = r_ostat;

        out_free  = !r_ovalid || o_chk.ready;
        segs_left = (r_seg < 3'(NUM_SEG));
        cur       = r_job.seg[r_seg[2:0] < 3'(NUM_SEG) ? r_seg : 3'd0];
        top       = r_acc >> (r_accn - 8'd64);

        if (r_ovalid && o_chk.ready) n_ovalid = 1'b0;

        if (!r_busy) begin
            if (i_job_valid) begin
                n_busy = 1'b1;
                n_job  = i_job;
                n_seg  = 3'd0;
                n_acc  = '0;
                n_accn = 8'd0;
            end
        end else if (r_job.full) begin
            if (out_free) begin
                n_ovalid = 1'b1;
                n_obits  = 64'd0;
                n_olen   = 7'd0;
                n_olast  = 1'b1;
                n_ostat  = 1'b1;
                n_busy   = 1'b0;
            end
        end else if (r_accn >= 8'd64 && (segs_left || r_accn > 8'd64)) begin
            if (out_free) begin
                n_ovalid = 1'b1;
                n_obits  = top[63:0];
                n_olen   = 7'd64;
                n_olast  = 1'b0;
                n_ostat  = 1'b0;
                n_accn   = r_accn - 8'd64;
            end
        end else if (segs_left) begin
            n_acc  = (r_acc << cur.len) | {64'd0, cur.bits};
            n_accn = r_accn + {1'b0, cur.len};
            n_seg  = r_seg + 3'd1;
        end else if (out_free) begin
            n_ovalid = 1'b1;
            n_obits  = r_acc[63:0] & len_mask(r_accn[6:0]);
            n_olen   = r_accn[6:0];
            n_olast  = 1'b1;
            n_ostat  = 1'b0;
            n_busy   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_seg   <= n_seg;
        r_acc   <= n_acc;
        r_accn  <= n_accn;
        r_obits <= n_obits;
        r_olen  <= n_olen;
        r_olast <= n_olast;
        r_ostat <= n_ostat;
    end

endmodule

// ----- hw/rtl/timeseries_sample_packer_core.sv -----
`timescale 1ns / 1ps
// Sample packer: each (time stamp, value) beat is coded as a delta-of-delta time
// field with a decimal exponent that only steps down, and an XOR value field, and
// leaves as one to three chunks of up to 64 bits, the final one marked last. If the
// code does not fit the page, one empty chunk with status set is returned and no
// state changes. The front takes a beat only when idle and runs difference, scan,
// a long division by ten for each step of the exponent search (up to seven of them,
// one byte per cycle), tier, classify and hand-over. The back drains a sample
// through a two-entry queue and overlaps the next sample's front work. The user
// must write registers only while the block is idle; the block does not enforce it.
module timeseries_sample_packer_core
    import tsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    tsp_in_if.sink      i_smp,
    tsp_out_if.source   o_chk
);

    t_job f_job;
    logic f_valid;
    logic f_ready;
    t_job b_job;
    logic b_valid;
    logic b_ready;

    tsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_smp       (i_smp),
        .o_job       (f_job),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready)
    );

    tsp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (f_job),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .o_job        (b_job),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready)
    );

    tsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (b_job),
        .i_job_valid (b_valid),
        .o_job_ready (b_ready),
        .o_chk       (o_chk)
    );

endmodule

// ----- hw/rtl/tsp_checker.sv -----
`timescale 1ns / 1ps
module tsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [63:0] i_bits,
    input logic [6:0]  i_len,
    input logic        i_last,
    input logic        i_status
);

    // A page-full beat is a single empty final chunk
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status |-> i_last && i_len == 7'd0 && i_bits == 64'd0)
        else $error("page-full beat not empty");

    // Only the final chunk of a sample may be short
    a_full_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last |-> i_len == 7'd64 && !i_status)
        else $error("short chunk before the last");

    // Chunk length never exceeds 64
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_len <= 7'd64)
        else $error("chunk length out of range");

    // Nothing is offered straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid after reset");

    // A stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_bits) && $stable(i_len))
        else $error("stalled beat changed");

endmodule

bind timeseries_sample_packer_core tsp_checker u_tsp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_chk.valid),
    .i_ready  (o_chk.ready),
    .i_bits   (o_chk.chunk_bits),
    .i_len    (o_chk.chunk_len),
    .i_last   (o_chk.last),
    .i_status (o_chk.status)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import tsp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    tsp_in_if  smp_if ();
    tsp_out_if chk_if ();

    timeseries_sample_packer_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp_if.sink),
        .o_chk      (chk_if.source)
    );

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 100;
    localparam int HOLD_CYCLES = 300;

    // One chunk as the block should return it
    typedef struct {
        logic [63:0] bits;
        logic [6:0]  len;
        logic        last;
        logic        status;
    } chunk_t;

    typedef enum int { ROW_CFG, ROW_SMP, ROW_SMP_KNOWN } row_kind_t;

    // Directed row: a register write, or a sample with or without a typed-in chunk
    typedef struct {
        row_kind_t   kind;
        logic [63:0] a;
        logic [63:0] b;
        chunk_t      want;
    } row_t;

    localparam logic [63:0] POW10 [8] = '{64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000,
                                          64'd100000, 64'd1000000, 64'd10000000};
    localparam int WIDE_W [8] = '{64, 61, 58, 55, 51, 48, 45, 41};

    // Predictor copy of registers and state
    logic [16:0] m_page_bits;
    logic [63:0] m_time, m_delta, m_value;
    logic [2:0]  m_exp;
    logic [4:0]  m_lead;
    logic [6:0]  m_wlen;
    logic [16:0] m_bit_pos;

    logic [191:0] code_buf;
    int           code_len;

    chunk_t chunk_q[$];
    bit     failed;
    bit     calm;
    bit     hold_req;
    int     n_samples, n_chunks, n_full;
    longint cycles;

    // Append n bits of v, first bit most significant
    function automatic void put_bits(input int n, input logic [63:0] v);
        for (int i = n; i > 0; i--) begin
            if (code_len < 192) begin
                code_buf[191 - code_len] = v[i-1];
                code_len++;
            end
        end
    endfunction

    // Sign-magnitude field, magnitude masked to n-1 bits
    function automatic void put_sm(input int n, input bit neg, input logic [63:0] mag);
        logic [63:0] f;
        f = mag & ((64'd1 << (n - 1)) - 64'd1);
        if (neg) f[n-1] = 1'b1;
        put_bits(n, f);
    endfunction

    function automatic void put_tier(input int e, input bit neg, input logic [63:0] m);
        if (m <= 64'd63) begin
            put_bits(2, 64'b10);
            put_sm(7, neg, m);
        end else if (m <= 64'd2047) begin
            put_bits(3, 64'b110);
            put_sm(12, neg, m);
        end else begin
            put_bits(4, 64'b1110);
            put_sm(WIDE_W[e], neg, m);
        end
    endfunction

    task automatic load_reg(input t_cfg_reg idx, input logic [63:0] d);
        case (idx)
            CFG_PAGE_BITS:  m_page_bits = d[16:0];
            CFG_START_POS:  m_bit_pos = {1'b0, d[15:0]};
            CFG_INIT_TIME:  m_time = {1'b0, d[62:0]};
            CFG_INIT_DELTA: m_delta = {1'b0, d[62:0]};
            CFG_INIT_VALUE: m_value = d;
            CFG_INIT_EXP:   m_exp = d[2:0];
            CFG_INIT_LEAD:  m_lead = d[4:0];
            default:        m_wlen = d[6:0];
        endcase
    endtask

    // Code one sample, update state and queue the chunks it should produce
    task automatic pack_sample(input logic [62:0] t, input logic [63:0] v);
        logic [63:0] dt, ddt, x, mag, q, w;
        int          e, nl, nw, lz, tz, pre, len, cap, avail, n, rem, clen;
        bit          neg;
        chunk_t      c;
        code_buf = '0;
        code_len = 0;
        dt  = {1'b0, t} - m_time;
        ddt = dt - m_delta;
        x   = v ^ m_value;
        e   = m_exp;
        nl  = m_lead;
        nw  = m_wlen;
        // time delta-of-delta
        if (ddt == 64'd0) begin
            put_bits(1, 64'd0);
        end else begin
            neg = ddt[63];
            mag = neg ? (64'd0 - ddt) : ddt;
            if (mag % POW10[e] != 0) begin
                while (e > 0 && mag % POW10[e] != 0) e--;
                put_bits(7, 64'h78 | e);
            end
            q = mag / POW10[e];
            put_tier(e, neg, neg ? q : q - 64'd1);
        end
        // value xor
        if (x == 64'd0) begin
            put_bits(1, 64'd0);
        end else begin
            lz = 0;
            tz = 0;
            while (lz < 64 && !x[63 - lz]) lz++;
            while (tz < 64 && !x[tz]) tz++;
            pre = lz < 31 ? lz : 31;
            len = 64 - pre - tz;
            if (nw >= 1 && nl + nw <= 64 && pre >= nl && pre + len <= nl + nw) begin
                put_bits(2, 64'b10);
                put_bits(nw, x >> (64 - nl - nw));
            end else begin
                nl = pre;
                nw = len;
                put_bits(13, {51'd0, 2'b11, pre[4:0], len[5:0]});
                put_bits(len, x >> (64 - pre - len));
            end
        end
        cap   = m_page_bits < PAGE_BITS_MAX ? m_page_bits : PAGE_BITS_MAX;
        avail = m_bit_pos < cap ? cap - m_bit_pos : 0;
        clen  = code_len;
        if (clen > avail) begin
            c = '{64'd0, 7'd0, 1'b1, 1'b1};
            chunk_q.push_back(c);
            n_full++;
        end else begin
            m_time    = {1'b0, t};
            m_delta   = dt;
            m_value   = v;
            m_exp     = 3'(e);
            m_lead    = 5'(nl);
            m_wlen    = 7'(nw);
            m_bit_pos = 17'(m_bit_pos + clen);
            n = (clen + 63) / 64;
            for (int k = 0; k < n; k++) begin
                rem = clen - k * 64;
                len = rem < 64 ? rem : 64;
                w   = code_buf[191 - 64*k -: 64];
                c.bits   = len == 64 ? w : w >> (64 - len);
                c.len    = 7'(len);
                c.last   = k == n - 1;
                c.status = 1'b0;
                chunk_q.push_back(c);
            end
        end
    endtask

    // One write beat, after which the port is left idle before the task returns
    task automatic write_reg(input t_cfg_reg idx, input logic [63:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        load_reg(idx, d);
        @(posedge i_clk);
    endtask

    // Wait for every queued chunk, then let the front settle
    task automatic drain();
        while (chunk_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Offer one beat, record it on acceptance, maybe idle afterwards
    task automatic send_sample(input logic [62:0] t, input logic [63:0] v,
                               input bit known, input chunk_t want);
        int gap;
        smp_if.valid      <= 1'b1;
        smp_if.time_stamp <= t;
        smp_if.value_bits <= v;
        do @(posedge i_clk); while (!smp_if.ready);
        n_samples++;
        if (known) begin
            pack_sample(t, v);
            void'(chunk_q.pop_back());
            chunk_q.push_back(want);
        end else begin
            pack_sample(t, v);
        end
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Result side: check each beat, stall in random bursts or on a long hold
    initial begin : result_side
        chunk_t want;
        int     stall;
        int     held;
        chk_if.ready = 1'b0;
        stall = 0;
        held  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (chk_if.valid && chk_if.ready) begin
                n_chunks++;
                if (chunk_q.size() == 0) begin
                    $error("unexpected chunk bits=%h len=%0d", chk_if.chunk_bits,
                           chk_if.chunk_len);
                    failed = 1'b1;
                end else begin
                    want = chunk_q.pop_front();
                    if (chk_if.chunk_bits !== want.bits) begin
                        $error("chunk_bits: expected %h got %h", want.bits, chk_if.chunk_bits);
                        failed = 1'b1;
                    end
                    if (chk_if.chunk_len !== want.len) begin
                        $error("chunk_len: expected %0d got %0d", want.len, chk_if.chunk_len);
                        failed = 1'b1;
                    end
                    if (chk_if.last !== want.last) begin
                        $error("last: expected %0b got %0b", want.last, chk_if.last);
                        failed = 1'b1;
                    end
                    if (chk_if.status !== want.status) begin
                        $error("status: expected %0b got %0b", want.status, chk_if.status);
                        failed = 1'b1;
                    end
                end
            end
            if (hold_req) begin
                held++;
                if (held >= HOLD_CYCLES) begin
                    hold_req = 1'b0;
                    held     = 0;
                end
                chk_if.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                chk_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 9) - 1;
                chk_if.ready <= 1'b0;
            end else begin
                chk_if.ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        row_t        rows[$];
        row_t        r;
        chunk_t      none;
        logic [62:0] g_time, t;
        logic [63:0] g_delta, g_val, v, step;
        longint      qm;
        int          kind, k, sh, wl;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_PAGE_BITS;
        i_cfg_data        = '0;
        smp_if.valid      = 1'b0;
        smp_if.time_stamp = '0;
        smp_if.value_bits = '0;
        failed    = 1'b0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        n_samples = 0;
        n_chunks  = 0;
        n_full    = 0;
        none      = '{64'd0, 7'd0, 1'b0, 1'b0};

        // state as it stands after reset
        m_page_bits = 17'd65536;
        m_time      = '0;
        m_delta     = '0;
        m_value     = '0;
        m_exp       = 3'd7;
        m_lead      = '0;
        m_wlen      = '0;
        m_bit_pos   = '0;

        // directed rows
        rows.push_back('{ROW_SMP_KNOWN, 64'd0, 64'd0, '{64'h0, 7'd2, 1'b1, 1'b0}});
        rows.push_back('{ROW_SMP_KNOWN, 64'd10000000, 64'd0,
                         '{64'h200, 7'd10, 1'b1, 1'b0}});
        rows.push_back('{ROW_SMP, 64'd20000000, 64'hFFFF_FFFF_FFFF_FFFF, none});
        rows.push_back('{ROW_SMP, 64'd30000000, 64'h0000_0000_0000_0001, none});
        rows.push_back('{ROW_SMP, 64'd40000000, 64'h8000_0000_0000_0001, none});
        rows.push_back('{ROW_SMP, 64'd40000001, 64'h8000_0000_0000_0003, none});
        rows.push_back('{ROW_SMP, 64'd40000500, 64'h8000_0000_0000_0002, none});
        rows.push_back('{ROW_SMP, 64'd40000000, 64'h0, none});
        rows.push_back('{ROW_SMP, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF, none});
        rows.push_back('{ROW_SMP, 64'd12345, 64'hFEDC_BA98_7654_3210, none});
        // most negative quotient at exponent zero
        rows.push_back('{ROW_CFG, CFG_INIT_EXP, 64'd0, none});
        rows.push_back('{ROW_CFG, CFG_INIT_TIME, 64'd0, none});
        rows.push_back('{ROW_CFG, CFG_INIT_DELTA, 64'd0, none});
        rows.push_back('{ROW_SMP, 64'h4000_0000_0000_0000, 64'h0, none});
        rows.push_back('{ROW_SMP, 64'd0, 64'h0, none});
        // window that can never be reused
        rows.push_back('{ROW_CFG, CFG_INIT_LEAD, 64'd31, none});
        rows.push_back('{ROW_CFG, CFG_INIT_WLEN, 64'd64, none});
        rows.push_back('{ROW_SMP, 64'd100, 64'h0000_0000_0000_00F0, none});
        // page full
        rows.push_back('{ROW_CFG, CFG_PAGE_BITS, 64'd0, none});
        rows.push_back('{ROW_SMP_KNOWN, 64'd5, 64'hAAAA, '{64'h0, 7'd0, 1'b1, 1'b1}});
        rows.push_back('{ROW_CFG, CFG_PAGE_BITS, 64'd65536, none});
        rows.push_back('{ROW_CFG, CFG_START_POS, 64'd0, none});
        rows.push_back('{ROW_SMP, 64'd7, 64'hAAAB, none});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            r = rows[i];
            if (r.kind == ROW_CFG) begin
                smp_if.valid <= 1'b0;
                drain();
                write_reg(t_cfg_reg'(r.a[2:0]), r.b);
            end else begin
                send_sample(r.a[62:0], r.b, r.kind == ROW_SMP_KNOWN, r.want);
            end
        end

        // random phases, each under a fresh register setting
        for (int ph = 0; ph < 6; ph++) begin
            smp_if.valid <= 1'b0;
            drain();
            calm = ph == 5;
            if (ph == 0) begin
                write_reg(CFG_PAGE_BITS, 64'd65536);
                write_reg(CFG_START_POS, 64'd65535);
                write_reg(CFG_INIT_TIME, 64'h7FFF_FFFF_FFFF_FFFF);
                write_reg(CFG_INIT_DELTA, 64'h7FFF_FFFF_FFFF_FFFF);
                write_reg(CFG_INIT_VALUE, 64'hFFFF_FFFF_FFFF_FFFF);
                write_reg(CFG_INIT_EXP, 64'd7);
                write_reg(CFG_INIT_LEAD, 64'd31);
                write_reg(CFG_INIT_WLEN, 64'd33);
            end else if (ph == 1) begin
                write_reg(CFG_PAGE_BITS, 64'd65536);
                write_reg(CFG_START_POS, 64'd0);
                write_reg(CFG_INIT_TIME, 64'd0);
                write_reg(CFG_INIT_DELTA, 64'd0);
                write_reg(CFG_INIT_VALUE, 64'd0);
                write_reg(CFG_INIT_EXP, 64'd0);
                write_reg(CFG_INIT_LEAD, 64'd0);
                write_reg(CFG_INIT_WLEN, 64'd0);
            end else begin
                write_reg(CFG_PAGE_BITS, $urandom_range(0, 1) ? 64'd65536
                                         : 64'($urandom_range(0, 65536)));
                write_reg(CFG_START_POS, ph == 3 ? 64'd60000 : 64'($urandom_range(0, 4000)));
                write_reg(CFG_INIT_TIME, rand64());
                write_reg(CFG_INIT_DELTA, 64'($urandom_range(0, 100000)));
                write_reg(CFG_INIT_VALUE, rand64());
                write_reg(CFG_INIT_EXP, 64'($urandom_range(0, 7)));
                write_reg(CFG_INIT_LEAD, 64'($urandom_range(0, 31)));
                write_reg(CFG_INIT_WLEN, 64'($urandom_range(0, 127)));
            end
            if (ph == 2) hold_req = 1'b1;
            g_time  = m_time[62:0];
            g_delta = m_delta;
            g_val   = m_value;
            for (int n = 0; n < 48; n++) begin
                kind = $urandom_range(0, 9);
                k    = $urandom_range(0, 7);
                // mostly regular spacing with delta-of-delta on a decimal grid
                if (kind <= 4) begin
                    qm = longint'($urandom_range(0, 6000)) - 3000;
                    if ($urandom_range(0, 3) == 0) qm = longint'($urandom_range(0, 20)) - 10;
                    step = g_delta + 64'(qm) * POW10[k];
                    t = g_time + step[62:0];
                end else if (kind <= 6) begin
                    t = g_time + g_delta[62:0];
                end else if (kind == 7) begin
                    t = 63'(rand64());
                end else if (kind == 8) begin
                    t = g_time - 63'($urandom_range(1, 1000));
                end else begin
                    t = g_time + 63'(rand64() >> $urandom_range(10, 63));
                end
                // value: same, a change inside a narrow window, a change at both ends, or noise
                kind = $urandom_range(0, 9);
                if (kind <= 1) begin
                    v = g_val;
                end else if (kind <= 6) begin
                    wl = $urandom_range(1, 24);
                    sh = $urandom_range(0, 64 - wl);
                    v  = g_val ^ ((rand64() & ((64'd1 << wl) - 1)) << sh);
                end else if (kind == 7) begin
                    v = g_val ^ {1'b1, 62'($urandom_range(0, 3)), 1'b1};
                end else begin
                    v = rand64();
                end
                send_sample(t, v, 1'b0, none);
                g_delta = {1'b0, t} - {1'b0, g_time};
                g_time  = t;
                g_val   = v;
            end
            // pause the sender until the block has emptied
            if (ph == 4) begin
                smp_if.valid <= 1'b0;
                while (chunk_q.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
        end

        smp_if.valid <= 1'b0;
        drain();
        $display("Sent %0d samples and checked %0d chunks, %0d of them page-full replies,",
                 n_samples, n_chunks, n_full);
        $display("from directed rows and six register settings, with a long output hold.");
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_in_if.sv
hw/rtl/tsp_out_if.sv
hw/rtl/tsp_front.sv
hw/rtl/tsp_queue.sv
hw/rtl/tsp_back.sv
hw/rtl/timeseries_sample_packer_core.sv
hw/rtl/tsp_checker.sv
bench/tb_top.sv
